[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files (included by sorted_priority_queue_top).
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/spq_pkg.sv]
// Package for the sorted priority queue: widths, codes and command/status types.
// No dependencies.
`default_nettype none
package spq_pkg;
  localparam int unsigned Capacity = 16;
  localparam int unsigned TagBits  = 32;
  localparam int unsigned PriBits  = 32;
  localparam int unsigned CntBits  = 5;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0, CMD_DEQ = 2'd1, CMD_CHG = 2'd2, CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_NOT_FOUND = 3'd2,
    ST_MORE_URGENT = 3'd3, ST_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_INSERT = 3'd1, OP_REMOVE_HEAD = 3'd2,
    OP_REMOVE_HIT = 3'd3, OP_CLEAR = 3'd4
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic hit_worse;
  } dp_stat_t;
endpackage
`default_nettype wire

[hw/rtl/spq_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface spq_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/spq_datapath.sv]
// Sorted cell chain: one slot per cell, parallel compare, shift insert/remove.
// Depends on spq_pkg.
`default_nettype none
module spq_datapath #(
  parameter int unsigned Capacity = spq_pkg::Capacity,
  parameter int unsigned TagBits  = spq_pkg::TagBits,
  parameter int unsigned CntBits  = $clog2(Capacity + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire spq_pkg::dp_cmd_t           cmd_i,
  input  wire logic [TagBits-1:0]         tag_i,
  input  wire logic signed [31:0]         pri_i,
  output spq_pkg::dp_stat_t               stat_o,
  output logic [TagBits-1:0]              head_tag_o,
  output logic signed [31:0]              head_pri_o,
  output logic [CntBits-1:0]              count_o
);
  logic [TagBits-1:0]     tag_q [Capacity];
  logic signed [31:0]     pri_q [Capacity];
  logic [Capacity-1:0]    occ_q, occ_d;
  logic [CntBits-1:0]     cnt_q, cnt_d;
  logic [Capacity-1:0]    ahead, match, first;
  logic [Capacity-1:0]    at_or_after;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      ahead[i] = occ_q[i] && (pri_q[i] < pri_i || (pri_q[i] == pri_i && tag_q[i] < tag_i));
      match[i] = occ_q[i] && (tag_q[i] == tag_i);
    end
    first = match & ~(match - Capacity'(1));
    at_or_after = (first - Capacity'(1)) ^ {Capacity{1'b1}};
  end

  always_comb begin
    stat_o.empty = !occ_q[0];
    stat_o.full  = occ_q[Capacity-1];
    stat_o.hit   = |match;
    stat_o.hit_worse = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      if (first[i] && pri_i > pri_q[i]) stat_o.hit_worse = 1'b1;
    end
  end

  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    unique case (cmd_i.op)
      spq_pkg::OP_INSERT: begin
        occ_d = {occ_q[Capacity-2:0], 1'b1};
        cnt_d = cnt_q + CntBits'(1);
      end
      spq_pkg::OP_REMOVE_HEAD, spq_pkg::OP_REMOVE_HIT: begin
        occ_d = occ_q >> 1;
        cnt_d = cnt_q - CntBits'(1);
      end
      spq_pkg::OP_CLEAR: begin
        occ_d = '0;
        cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cnt_q <= '0;
    end else begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Capacity; i++) begin
      case (cmd_i.op)
        spq_pkg::OP_INSERT: begin
          if (!ahead[i]) begin
            if (i == 0 || ahead[i-1 < 0 ? 0 : i-1]) begin
              tag_q[i] <= tag_i;
              pri_q[i] <= pri_i;
            end else begin
              tag_q[i] <= tag_q[i-1 < 0 ? 0 : i-1];
              pri_q[i] <= pri_q[i-1 < 0 ? 0 : i-1];
            end
          end
        end
        spq_pkg::OP_REMOVE_HEAD: begin
          if (i < Capacity - 1) begin
            tag_q[i] <= tag_q[i+1 >= Capacity ? i : i+1];
            pri_q[i] <= pri_q[i+1 >= Capacity ? i : i+1];
          end
        end
        spq_pkg::OP_REMOVE_HIT: begin
          if (at_or_after[i] && i < Capacity - 1) begin
            tag_q[i] <= tag_q[i+1 >= Capacity ? i : i+1];
            pri_q[i] <= pri_q[i+1 >= Capacity ? i : i+1];
          end
        end
        default: ;
      endcase
    end
  end

  assign head_tag_o = tag_q[0];
  assign head_pri_o = pri_q[0];
  assign count_o    = cnt_q;
endmodule
`default_nettype wire

[hw/rtl/spq_ctrl.sv]
// Controller: decodes commands, sequences remove/insert, drives the result register load.
// Depends on spq_pkg.
`default_nettype none
module spq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire spq_pkg::dp_stat_t stat_i,
  output spq_pkg::dp_cmd_t       dp_cmd_o,
  output logic                   res_load_o,
  output logic [2:0]             res_status_o,
  output logic                   res_pop_o,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REINS = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic [2:0] st_q, st_d;
  logic       pop_q, pop_d;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_i || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    pop_d = 1'b0;
    dp_cmd_o.op = spq_pkg::OP_NONE;
    res_load_o = 1'b0;
    res_status_o = st_q;
    res_pop_o = pop_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d = spq_pkg::ST_OK;
          state_d = S_LOAD;
          unique case (cmd_i)
            spq_pkg::CMD_ENQ: begin
              if (stat_i.full) st_d = spq_pkg::ST_FULL;
              else dp_cmd_o.op = spq_pkg::OP_INSERT;
            end
            spq_pkg::CMD_DEQ: begin
              if (stat_i.empty) st_d = spq_pkg::ST_EMPTY;
              else begin
                dp_cmd_o.op = spq_pkg::OP_REMOVE_HEAD;
                pop_d = 1'b1;
              end
            end
            spq_pkg::CMD_CHG: begin
              if (!stat_i.hit) st_d = spq_pkg::ST_NOT_FOUND;
              else if (stat_i.hit_worse) st_d = spq_pkg::ST_MORE_URGENT;
              else begin
                dp_cmd_o.op = spq_pkg::OP_REMOVE_HIT;
                state_d = S_REINS;
              end
            end
            default: dp_cmd_o.op = spq_pkg::OP_CLEAR;
          endcase
        end
      end
      S_REINS: begin
        dp_cmd_o.op = spq_pkg::OP_INSERT;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        res_load_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q <= spq_pkg::ST_OK;
      pop_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        st_q <= st_d;
        pop_q <= pop_d;
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sorted_priority_queue_top.sv]
// Sorted priority queue: the result register loads in state S_LOAD, entered straight after
// acceptance, or after S_REINS for a change of priority (remove pass, then insert pass).
// One command at a time; the next is taken once the result register is free.
// A new command waits until the controller is back in S_IDLE after the cell chain update.
// Asynchronous active-low reset empties the queue and clears the result valid flag.
`default_nettype none
module sorted_priority_queue_top #(
  parameter int unsigned Capacity = spq_pkg::Capacity
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_if.sink       in_if,
  spq_if.source     out_if
);
  localparam int unsigned CntBits = $clog2(Capacity + 1);

  spq_pkg::dp_cmd_t  dp_cmd;
  spq_pkg::dp_stat_t dp_stat;
  logic [31:0] head_tag;
  logic signed [31:0] head_pri;
  logic [CntBits-1:0] count;
  logic res_load, res_pop;
  logic [2:0] res_status;
  logic [31:0] pop_tag_q;
  logic out_valid_q;
  logic [31:0] in_tag;
  logic signed [31:0] in_pri;
  logic [1:0] in_cmd;

  assign in_cmd = in_if.data.command;
  assign in_tag = in_if.data.item_value;
  assign in_pri = in_if.data.item_priority;

  spq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .cmd_i(in_cmd), .stat_i(dp_stat), .dp_cmd_o(dp_cmd),
    .res_load_o(res_load), .res_status_o(res_status), .res_pop_o(res_pop),
    .out_valid_i(out_valid_q), .out_ready_i(out_if.ready)
  );

  logic [31:0] arg_tag_q;
  logic signed [31:0] arg_pri_q;
  logic [31:0] dp_tag;
  logic signed [31:0] dp_pri;
  logic in_acc;
  assign in_acc = in_if.valid && in_if.ready;
  assign dp_tag = in_acc ? in_tag : arg_tag_q;
  assign dp_pri = in_acc ? in_pri : arg_pri_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      arg_tag_q <= in_tag;
      arg_pri_q <= in_pri;
      pop_tag_q <= head_tag;
    end
  end

  spq_datapath #(.Capacity(Capacity), .TagBits(32), .CntBits(CntBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .tag_i(dp_tag), .pri_i(dp_pri),
    .stat_o(dp_stat), .head_tag_o(head_tag), .head_pri_o(head_pri), .count_o(count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_if.data.status        <= spq_pkg::status_e'(res_status);
      out_if.data.popped_value  <= res_pop ? pop_tag_q : '0;
      out_if.data.head_valid    <= (count != '0);
      out_if.data.head_value    <= (count != '0) ? head_tag : '0;
      out_if.data.head_priority <= (count != '0) ? head_pri : '0;
      out_if.data.entry_count   <= 5'(count);
    end
  end

  assign out_if.valid = out_valid_q;

`include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_range, count <= CntBits'(Capacity), "count over capacity")
  `ASSERT_NEXT(a_no_overrun, out_valid_q && !out_if.ready && !res_load, out_valid_q, "result lost")
  `ASSERT_IMPL(a_ready_idle, !(in_if.ready && out_valid_q && !out_if.ready), "ready while blocked")
endmodule
`default_nettype wire
